FILE: hdl/azsc_pkg.sv
// ----------------------------------------------------------------------------
// azsc_pkg
// Types, codes and the AZERTY lookup table for the scancode decoder.
// ----------------------------------------------------------------------------
package azsc_pkg;

  typedef logic [7:0] scan_t;
  typedef logic [6:0] ascii_t;
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_NONE  = 3'd0;
  localparam kind_t KIND_CHAR  = 3'd1;
  localparam kind_t KIND_INTR  = 3'd2;
  localparam kind_t KIND_CLEAR = 3'd3;
  localparam kind_t KIND_RAW   = 3'd4;

  localparam scan_t SC_ESC        = 8'h01;
  localparam scan_t SC_LSHIFT     = 8'h2A;
  localparam scan_t SC_RSHIFT     = 8'h36;
  localparam scan_t SC_LSHIFT_BRK = 8'hAA;
  localparam scan_t SC_RSHIFT_BRK = 8'hB6;
  localparam scan_t SC_CTRL       = 8'h1D;
  localparam scan_t SC_CTRL_BRK   = 8'h9D;
  localparam scan_t SC_ROW_FIRST  = 8'h02;
  localparam scan_t SC_ROW_LAST   = 8'h0B;
  localparam scan_t SC_ROW_ZERO   = 8'h0B;

  localparam ascii_t CH_NUL    = 7'h00;
  localparam ascii_t CH_LOW_A  = 7'h61;
  localparam ascii_t CH_LOW_Z  = 7'h7A;
  localparam ascii_t CH_LOW_C  = 7'h63;
  localparam ascii_t CH_LOW_L  = 7'h6C;
  localparam ascii_t CH_ZERO   = 7'h30;
  localparam ascii_t CH_ONE    = 7'h31;
  localparam ascii_t CASE_GAP  = 7'h20;

  typedef struct packed {
    kind_t  kind;
    ascii_t char_code;
    scan_t  raw_code;
  } result_t;

  typedef struct packed {
    logic shift_held;
    logic control_held;
  } flags_t;

  // AZERTY make-code table; zero means no entry
  function automatic ascii_t azerty_lookup(input logic [6:0] idx);
    ascii_t ch;
    ch = CH_NUL;
    case (idx)
      7'h02: ch = 7'h26; // &
      7'h03: ch = 7'h65; // e
      7'h04: ch = 7'h22; // "
      7'h05: ch = 7'h27; // '
      7'h06: ch = 7'h28; // (
      7'h07: ch = 7'h2D; // -
      7'h08: ch = 7'h65; // e
      7'h09: ch = 7'h5F; // _
      7'h0A: ch = 7'h63; // c
      7'h0B: ch = 7'h61; // a
      7'h0C: ch = 7'h29; // )
      7'h0D: ch = 7'h3D; // =
      7'h0E: ch = 7'h08; // backspace
      7'h0F: ch = 7'h09; // tab
      7'h10: ch = 7'h61; // a
      7'h11: ch = 7'h7A; // z
      7'h12: ch = 7'h65; // e
      7'h13: ch = 7'h72; // r
      7'h14: ch = 7'h74; // t
      7'h15: ch = 7'h79; // y
      7'h16: ch = 7'h75; // u
      7'h17: ch = 7'h69; // i
      7'h18: ch = 7'h6F; // o
      7'h19: ch = 7'h70; // p
      7'h1A: ch = 7'h5E; // ^
      7'h1B: ch = 7'h24; // $
      7'h1C: ch = 7'h0A; // newline
      7'h1E: ch = 7'h71; // q
      7'h1F: ch = 7'h73; // s
      7'h20: ch = 7'h64; // d
      7'h21: ch = 7'h66; // f
      7'h22: ch = 7'h67; // g
      7'h23: ch = 7'h68; // h
      7'h24: ch = 7'h6A; // j
      7'h25: ch = 7'h6B; // k
      7'h26: ch = 7'h6C; // l
      7'h27: ch = 7'h6D; // m
      7'h28: ch = 7'h75; // u
      7'h29: ch = 7'h2A; // *
      7'h2B: ch = 7'h3C; // <
      7'h2C: ch = 7'h77; // w
      7'h2D: ch = 7'h78; // x
      7'h2E: ch = 7'h63; // c
      7'h2F: ch = 7'h76; // v
      7'h30: ch = 7'h62; // b
      7'h31: ch = 7'h6E; // n
      7'h32: ch = 7'h2C; // ,
      7'h33: ch = 7'h3B; // ;
      7'h34: ch = 7'h3A; // :
      7'h35: ch = 7'h21; // !
      7'h39: ch = 7'h20; // space
      7'h56: ch = 7'h3E; // >
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/azsc_if.sv
// ----------------------------------------------------------------------------
// azsc_if
// Valid/ready channels for scancode requests and decoded results.
// ----------------------------------------------------------------------------
interface azsc_in_if;
  logic            valid;
  logic            ready;
  azsc_pkg::scan_t scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface azsc_out_if;
  logic             valid;
  logic             ready;
  azsc_pkg::kind_t  kind;
  azsc_pkg::ascii_t char_code;
  azsc_pkg::scan_t  raw_code;

  modport source (output valid, output kind, output char_code, output raw_code,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input raw_code,
                  output ready);
endinterface

FILE: hdl/azerty_scancode_to_char_top.sv
// ----------------------------------------------------------------------------
// azerty_scancode_to_char_top
// Set-1 scancode to AZERTY character decoder with shift and control tracking.
// ----------------------------------------------------------------------------
// Each accepted scancode request yields exactly one result, in order. A
// request is captured in an input register, decoded against the shift and
// control flags by combinational logic and lands in the result register, so a new
// request is taken every clock while the result side keeps up; the result is
// presented from the result register and held there until it is taken.
// Modifier make/break codes, other breaks and Escape give kind "nothing";
// unmapped make codes echo the raw byte. Both flags clear on reset.
module azerty_scancode_to_char_top (
  input  logic       clk,
  input  logic       rst_n,
  azsc_in_if.sink    in_ch,
  azsc_out_if.source out_ch
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  azsc_pkg::scan_t   s1_code_r;
  azsc_pkg::flags_t  flags_r;
  azsc_pkg::flags_t  flags_dec;
  azsc_pkg::result_t res_dec;
  logic              out_valid_r;
  logic              out_valid_nxt;
  azsc_pkg::result_t out_res_r;
  logic              out_free;
  logic              s1_go;
  logic              in_take;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_go        = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_ch.ready);

  azsc_decode u_decode (
    .code      (s1_code_r),
    .flags     (flags_r),
    .result    (res_dec),
    .flags_nxt (flags_dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        flags_r <= flags_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_ch.scan_code;
    end
    if (s1_go) begin
      out_res_r <= res_dec;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_res_r.kind;
  assign out_ch.char_code = out_res_r.char_code;
  assign out_ch.raw_code  = out_res_r.raw_code;

endmodule

FILE: hdl/azsc_decode.sv
// ----------------------------------------------------------------------------
// azsc_decode
// Combinational decode of one scancode against the current modifier flags.
// ----------------------------------------------------------------------------
module azsc_decode (
  input  azsc_pkg::scan_t   code,
  input  azsc_pkg::flags_t  flags,
  output azsc_pkg::result_t result,
  output azsc_pkg::flags_t  flags_nxt
);

  azsc_pkg::ascii_t ch;
  azsc_pkg::ascii_t ch_shift;
  logic             is_row;

  assign ch     = azsc_pkg::azerty_lookup(code[6:0]);
  assign is_row = (code >= azsc_pkg::SC_ROW_FIRST) && (code <= azsc_pkg::SC_ROW_LAST);

  always_comb begin
    ch_shift = ch;
    if ((ch >= azsc_pkg::CH_LOW_A) && (ch <= azsc_pkg::CH_LOW_Z)) begin
      ch_shift = ch - azsc_pkg::CASE_GAP;
    end
    if (is_row) begin
      if (code == azsc_pkg::SC_ROW_ZERO) begin
        ch_shift = azsc_pkg::CH_ZERO;
      end else begin
        ch_shift = azsc_pkg::CH_ONE + (code[6:0] - azsc_pkg::SC_ROW_FIRST[6:0]);
      end
    end
  end

  always_comb begin
    flags_nxt = flags;
    result    = '{kind: azsc_pkg::KIND_NONE, char_code: azsc_pkg::CH_NUL,
                  raw_code: '0};
    if ((code == azsc_pkg::SC_LSHIFT) || (code == azsc_pkg::SC_RSHIFT)) begin
      flags_nxt.shift_held = 1'b1;
    end else if ((code == azsc_pkg::SC_LSHIFT_BRK) ||
                 (code == azsc_pkg::SC_RSHIFT_BRK)) begin
      flags_nxt.shift_held = 1'b0;
    end else if (code == azsc_pkg::SC_CTRL) begin
      flags_nxt.control_held = 1'b1;
    end else if (code == azsc_pkg::SC_CTRL_BRK) begin
      flags_nxt.control_held = 1'b0;
    end else if (code[7] || (code == azsc_pkg::SC_ESC)) begin
      result.kind = azsc_pkg::KIND_NONE;
    end else if (ch == azsc_pkg::CH_NUL) begin
      result.kind     = azsc_pkg::KIND_RAW;
      result.raw_code = code;
    end else if (flags.control_held && (ch == azsc_pkg::CH_LOW_C)) begin
      result.kind = azsc_pkg::KIND_INTR;
    end else if (flags.control_held && (ch == azsc_pkg::CH_LOW_L)) begin
      result.kind = azsc_pkg::KIND_CLEAR;
    end else begin
      result.kind      = azsc_pkg::KIND_CHAR;
      result.char_code = flags.shift_held ? ch_shift : ch;
    end
  end

endmodule
